FILE: rtl/core/tkcl_pkg.sv
// Package for the touch keypad code lock: sizes, key classes and the
// channel-to-key decode. Depends on nothing; used by the interfaces and the top level.
package tkcl_pkg;

	// Number of digits in a complete entry.
	localparam int PASSWORD_LEN = 6;
	// Digits held by the stored-code register, one per nibble.
	localparam int CODE_DIGITS  = 6;
	localparam int CODE_W       = 4 * CODE_DIGITS;
	localparam int DIGIT_W      = 4;
	localparam int STATUS_W     = 8;
	// Entry count runs from zero up to PASSWORD_LEN inclusive.
	localparam int CNT_W        = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN + 1) : 1;
	// Slot index into the entered digits.
	localparam int IDX_W        = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
	// Channels that are looked at, from 1 upwards.
	localparam int NUM_CHAN     = 14;
	localparam logic [1:0] FIELD_PRESSED = 2'b11;

	typedef enum logic [1:0] {
		KEY_NONE  = 2'd0,
		KEY_DIGIT = 2'd1,
		KEY_CLEAR = 2'd2,
		KEY_ENTER = 2'd3
	} key_kind_t;

	typedef struct packed {
		key_kind_t           kind;
		logic [DIGIT_W-1:0]  digit;
	} key_t;

	// Fixed keypad layout: channel number to key.
	function automatic key_t chan_key(input logic [3:0] chan);
		key_t k;
		k.kind  = KEY_DIGIT;
		k.digit = '0;
		unique case (chan)
			4'd2:    k.digit = 4'd5;
			4'd3:    k.digit = 4'd2;
			4'd4:    k.digit = 4'd8;
			4'd5:    k.digit = 4'd3;
			4'd6:    k.digit = 4'd6;
			4'd7:    k.digit = 4'd9;
			4'd8:    k.kind  = KEY_ENTER;
			4'd9:    k.digit = 4'd0;
			4'd10:   k.kind  = KEY_CLEAR;
			4'd11:   k.digit = 4'd7;
			4'd12:   k.digit = 4'd4;
			4'd13:   k.digit = 4'd1;
			default: k.kind  = KEY_NONE;
		endcase
		return k;
	endfunction

	// Lowest pressed channel among 1 to 14 selects the key; none gives KEY_NONE.
	function automatic key_t decode_key(
		input logic [STATUS_W-1:0] b0,
		input logic [STATUS_W-1:0] b1,
		input logic [STATUS_W-1:0] b2,
		input logic [STATUS_W-1:0] b3
	);
		logic [4*STATUS_W-1:0] fields;
		logic [3:0]            chan;
		fields = {b3, b2, b1, b0};
		chan   = 4'd0;
		for (int c = NUM_CHAN; c >= 1; c--) begin
			if (fields[2*(c-1) +: 2] == FIELD_PRESSED) begin
				chan = 4'(c);
			end
		end
		return chan_key(chan);
	endfunction

endpackage

FILE: rtl/core/tkcl_if.sv
// Handshake interfaces for the touch keypad code lock: touch events in, verdicts out.
// Depends on tkcl_pkg for the field widths.
interface tkcl_event_if;
	logic                           valid;
	logic                           ready;
	logic [tkcl_pkg::STATUS_W-1:0]  status_byte_0;
	logic [tkcl_pkg::STATUS_W-1:0]  status_byte_1;
	logic [tkcl_pkg::STATUS_W-1:0]  status_byte_2;
	logic [tkcl_pkg::STATUS_W-1:0]  status_byte_3;

	modport source (
		output valid, status_byte_0, status_byte_1, status_byte_2, status_byte_3,
		input  ready
	);
	modport sink (
		input  valid, status_byte_0, status_byte_1, status_byte_2, status_byte_3,
		output ready
	);
endinterface

interface tkcl_result_if;
	logic valid;
	logic ready;
	logic code_matched;

	modport source (output valid, code_matched, input ready);
	modport sink   (input valid, code_matched, output ready);
endinterface

FILE: rtl/core/touch_keypad_code_lock_unit.sv
// Top level of the touch keypad code lock: event register, key decode, entry
// state and verdict register. Depends on tkcl_pkg and the interfaces in tkcl_if.sv.
//
// Usage:
// - evt carries one touch event per transaction: four channel status bytes.
// - res carries one verdict per complete entry confirmed by the enter key:
//   code_matched is 1 when the entry equals stored_code, 0 otherwise.
// - cfg_we/cfg_wdata write stored_code (first digit in the low nibble); write
//   it only while no event is in flight.
// - A verdict is offered on res from the verdict register, after its event has
//   passed the event register; events that give no verdict leave no trace on res.
// - Throughput: one event per cycle while no verdict waits on a stalled res, set
//   by the single event register feeding the entry logic and the verdict register.
// - When res stalls, a waiting verdict holds; events that give no verdict keep
//   flowing, and an enter with a full entry waits in the event register.
// - Reset empties the entry, clears both valid flags and sets stored_code to 0.
module touch_keypad_code_lock_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	tkcl_event_if.sink                    evt,
	tkcl_result_if.source                 res,
	input  logic                          cfg_we,
	input  logic [tkcl_pkg::CODE_W-1:0]   cfg_wdata
);

	logic                              valid_s1;
	logic [tkcl_pkg::STATUS_W-1:0]     byte0_s1;
	logic [tkcl_pkg::STATUS_W-1:0]     byte1_s1;
	logic [tkcl_pkg::STATUS_W-1:0]     byte2_s1;
	logic [tkcl_pkg::STATUS_W-1:0]     byte3_s1;

	logic [tkcl_pkg::CODE_W-1:0]       stored_code_q;
	logic [tkcl_pkg::DIGIT_W-1:0]      digits_q [tkcl_pkg::PASSWORD_LEN];
	logic [tkcl_pkg::CNT_W-1:0]        count_q;
	logic                              res_valid_q;
	logic                              matched_q;

	tkcl_pkg::key_t                    key_s1;
	logic                              full;
	logic                              wants_res;
	logic                              out_free;
	logic                              advance;
	logic                              match;

	// Event register: takes a new transaction when it is empty or the held one moves on.
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			byte0_s1 <= evt.status_byte_0;
			byte1_s1 <= evt.status_byte_1;
			byte2_s1 <= evt.status_byte_2;
			byte3_s1 <= evt.status_byte_3;
		end
	end

	// Key decode and the hand-off condition for the held event.
	always_comb begin
		key_s1    = tkcl_pkg::decode_key(byte0_s1, byte1_s1, byte2_s1, byte3_s1);
		full      = (count_q == tkcl_pkg::CNT_W'(tkcl_pkg::PASSWORD_LEN));
		wants_res = (key_s1.kind == tkcl_pkg::KEY_ENTER) && full;
		out_free  = !res_valid_q || res.ready;
		advance   = valid_s1 && (!wants_res || out_free);
	end

	// Compare the complete entry with the stored code; digits past the register read as zero.
	always_comb begin
		match = 1'b1;
		for (int k = 0; k < tkcl_pkg::PASSWORD_LEN; k++) begin
			if (k < tkcl_pkg::CODE_DIGITS) begin
				if (digits_q[k] != stored_code_q[(4*k) % tkcl_pkg::CODE_W +: 4]) begin
					match = 1'b0;
				end
			end else if (digits_q[k] != '0) begin
				match = 1'b0;
			end
		end
	end

	// Stored code register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_code_q <= '0;
		end else if (cfg_we) begin
			stored_code_q <= cfg_wdata;
		end
	end

	// Entry count: append, clear and enter all act when the event moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance) begin
			unique case (key_s1.kind)
				tkcl_pkg::KEY_DIGIT: begin
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
				end
				tkcl_pkg::KEY_CLEAR,
				tkcl_pkg::KEY_ENTER: count_q <= '0;
				default: ;
			endcase
		end
	end

	// Entered digits: written at the slot the count points to.
	always_ff @(posedge clk) begin
		if (advance && key_s1.kind == tkcl_pkg::KEY_DIGIT && !full) begin
			digits_q[count_q[tkcl_pkg::IDX_W-1:0]] <= key_s1.digit;
		end
	end

	// Verdict register: holds until the receiver takes the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && wants_res) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wants_res) begin
			matched_q <= match;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.code_matched = matched_q;

`ifndef SYNTHESIS
	// Clear and enter both leave an empty entry.
	a_empty_after_clear_or_enter: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (key_s1.kind == tkcl_pkg::KEY_CLEAR || key_s1.kind == tkcl_pkg::KEY_ENTER)
		|=> count_q == '0)
		else $error("entry not emptied after clear or enter");

	// A digit on a partial entry grows the count by exactly one.
	a_digit_appends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && key_s1.kind == tkcl_pkg::KEY_DIGIT && !full
		|=> count_q == $past(count_q) + 1'b1)
		else $error("digit not appended");

	// The count never passes the entry length.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tkcl_pkg::CNT_W'(tkcl_pkg::PASSWORD_LEN))
		else $error("entry count out of range");

	// A waiting verdict is never overwritten by a new one.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !(advance && wants_res))
		else $error("verdict overwritten while stalled");
`endif

endmodule
